// ===== sv/wrot_pkg.sv =====
// Shared constants and types for the write range overlap trimmer.
package wrot_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_BITS   = 48;
  localparam int LEN_BITS    = 16;
  localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
  localparam int FILL_BITS   = SLOT_BITS + 1;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_MARK = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // Request that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                 valid;
    logic [1:0]           op;
    logic [ADDR_BITS-1:0] s;
    logic [LEN_BITS-1:0]  n;
    logic [LEN_BITS-1:0]  wl;
    logic                 cv;
    logic [SLOT_BITS-1:0] cs;
    logic [FILL_BITS-1:0] fill;
    logic                 hit;
    logic                 reject;
    logic                 split;
    logic [ADDR_BITS-1:0] sp_start;
    logic [LEN_BITS-1:0]  sp_count;
    logic                 sp_copied;
    logic [LEN_BITS-1:0]  sp_len;
    logic [SLOT_BITS-1:0] r_slot;
    logic [ADDR_BITS-1:0] r_start;
    logic [LEN_BITS-1:0]  r_count;
    logic [ADDR_BITS-1:0] r_rs;
    logic [LEN_BITS-1:0]  r_rc;
  } msg_t;

  // Append write broadcast to all cells.
  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] idx;
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  count;
    logic [ADDR_BITS-1:0] rs;
    logic [LEN_BITS-1:0]  rc;
    logic                 copied;
  } wr_t;

endpackage

// ===== sv/wrot_cell.sv =====
// One table entry cell: trims, matches and forwards the request to its neighbor.
module wrot_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [wrot_pkg::SLOT_BITS-1:0]  cell_idx,
  input  wrot_pkg::msg_t                  msg_i,
  input  wrot_pkg::wr_t                   wr0,
  input  wrot_pkg::wr_t                   wr1,
  output wrot_pkg::msg_t                  msg_o
);

  logic [wrot_pkg::ADDR_BITS-1:0] e_start, e_start_next, e_rs, e_rs_next;
  logic [wrot_pkg::LEN_BITS-1:0]  e_count, e_count_next, e_rc, e_rc_next;
  logic                           e_copied, e_copied_next;
  wrot_pkg::msg_t                 msg_next;

  logic                           live, ov, lower, split_here, full, blocked, front;
  logic [wrot_pkg::ADDR_BITS-1:0] diff_hs, diff_sh;
  logic [wrot_pkg::ADDR_BITS-1:0] wl_a, rc_a;
  logic [wrot_pkg::LEN_BITS-1:0]  d_lo, d_hi, step;
  logic [wrot_pkg::LEN_BITS:0]    rest;
  logic                           load;

  always_comb begin
    live    = msg_i.valid &&
              ({1'b0, cell_idx} < msg_i.fill);
    diff_hs = e_rs - msg_i.s;
    diff_sh = msg_i.s - e_rs;
    wl_a    = wrot_pkg::ADDR_BITS'(msg_i.wl);
    rc_a    = wrot_pkg::ADDR_BITS'(e_rc);
    ov      = (e_rc != '0) && (msg_i.wl != '0) &&
              ((e_rs < msg_i.s) || (diff_hs < wl_a)) &&
              ((msg_i.s < e_rs) || (diff_sh < rc_a));
    lower   = e_rs < msg_i.s;
    d_lo    = diff_sh[wrot_pkg::LEN_BITS-1:0];
    d_hi    = diff_hs[wrot_pkg::LEN_BITS-1:0];
    step    = msg_i.wl - d_hi;
    rest    = {1'b0, e_rc} - {1'b0, d_lo};
    split_here = live && (msg_i.op == wrot_pkg::OP_PUSH) && ov && lower &&
                 ({1'b0, msg_i.wl} < rest);
    full    = msg_i.fill == wrot_pkg::FILL_BITS'(wrot_pkg::TABLE_DEPTH);
    blocked = full ||
              (split_here && (msg_i.fill == wrot_pkg::FILL_BITS'(wrot_pkg::TABLE_DEPTH - 1)));
    front   = !msg_i.cv || ({1'b0, msg_i.cs} >= msg_i.fill);

    e_start_next  = e_start;
    e_count_next  = e_count;
    e_rs_next     = e_rs;
    e_rc_next     = e_rc;
    e_copied_next = e_copied;
    msg_next      = msg_i;
    load          = 1'b0;

    if (live && (msg_i.op == wrot_pkg::OP_PUSH) && ov) begin
      if (blocked) begin
        // leave the table untouched on a full reject
        msg_next.reject = !full || msg_i.reject;
      end else if (!lower) begin
        if (e_rc <= step) begin
          e_rc_next = '0;
        end else begin
          e_rs_next = e_rs + wrot_pkg::ADDR_BITS'(step);
          e_rc_next = e_rc - step;
        end
      end else begin
        e_rc_next = d_lo;
      end
      if (split_here) begin
        msg_next.split     = 1'b1;
        msg_next.sp_start  = e_start;
        msg_next.sp_count  = e_count;
        msg_next.sp_copied = e_copied;
        msg_next.sp_len    = rest[wrot_pkg::LEN_BITS-1:0] - msg_i.wl;
      end
    end

    if (live && (msg_i.op == wrot_pkg::OP_GET) && !msg_i.hit) begin
      if (front) begin
        load = cell_idx == '0;
      end else begin
        load = (cell_idx > msg_i.cs) && !e_copied;
      end
    end
    if (live && (msg_i.op == wrot_pkg::OP_MARK) && msg_i.cv && (cell_idx == msg_i.cs)) begin
      e_copied_next = 1'b1;
      load          = 1'b1;
    end
    if (load) begin
      msg_next.hit     = 1'b1;
      msg_next.r_slot  = cell_idx;
      msg_next.r_start = e_start;
      msg_next.r_count = e_count;
      msg_next.r_rs    = e_rs;
      msg_next.r_rc    = e_rc;
    end

    // appends land in free slots only, never in a cell the request is using
    if (wr0.en && (wr0.idx == cell_idx)) begin
      e_start_next  = wr0.start;
      e_count_next  = wr0.count;
      e_rs_next     = wr0.rs;
      e_rc_next     = wr0.rc;
      e_copied_next = wr0.copied;
    end else if (wr1.en && (wr1.idx == cell_idx)) begin
      e_start_next  = wr1.start;
      e_count_next  = wr1.count;
      e_rs_next     = wr1.rs;
      e_rc_next     = wr1.rc;
      e_copied_next = wr1.copied;
    end
  end

  always_ff @(posedge clk) begin
    e_start  <= e_start_next;
    e_count  <= e_count_next;
    e_rs     <= e_rs_next;
    e_rc     <= e_rc_next;
    e_copied <= e_copied_next;
    if (rst) begin
      msg_o <= '0;
    end else begin
      msg_o <= msg_next;
    end
  end

endmodule

// ===== sv/write_range_overlap_trimmer_top.sv =====
// Top level: request injection, cell chain, append logic and result register.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request item: opcode, start_block,
//   block_count, cursor_valid, cursor_slot. Output channel (out_valid/out_stall)
//   returns exactly one result item per request: status, slot, entry range and
//   readable subrange.
//   A request enters a head register, then walks the chain of TABLE_DEPTH entry
//   cells one cell per cycle; each cell trims, matches or marks its own entry.
//   After the last cell the appends are written and the result is registered.
//   One request is in flight at a time, so a new item is not taken until the
//   result of the last one has been taken.
//   in_stall is high from acceptance until the result is taken.
//   While out_stall is high the result holds steady and no new item is taken.
//   Reset empties the table (fill level zero) and clears all handshake state;
//   entry contents are not cleared and are never read before being appended.
module write_range_overlap_trimmer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [wrot_pkg::ADDR_BITS-1:0]  start_block,
  input  logic [wrot_pkg::LEN_BITS-1:0]   block_count,
  input  logic                            cursor_valid,
  input  logic [wrot_pkg::SLOT_BITS-1:0]  cursor_slot,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [wrot_pkg::SLOT_BITS-1:0]  slot,
  output logic [wrot_pkg::ADDR_BITS-1:0]  seg_start,
  output logic [wrot_pkg::LEN_BITS-1:0]   seg_count,
  output logic [wrot_pkg::ADDR_BITS-1:0]  read_start,
  output logic [wrot_pkg::LEN_BITS-1:0]   read_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]                     state, state_next;
  logic [wrot_pkg::FILL_BITS-1:0] fill_level, fill_level_next;
  wrot_pkg::msg_t                 head, head_next, last;
  wrot_pkg::msg_t                 link [wrot_pkg::TABLE_DEPTH];
  wrot_pkg::wr_t                  wr0, wr1;
  logic                           in_acc, out_acc;
  logic [wrot_pkg::ADDR_BITS-1:0] space;
  logic [1:0]                     status_next;
  logic [wrot_pkg::SLOT_BITS-1:0] slot_next, new_idx;
  logic [wrot_pkg::ADDR_BITS-1:0] seg_start_next, read_start_next;
  logic [wrot_pkg::LEN_BITS-1:0]  seg_count_next, read_count_next;
  logic                           rejected;

  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign last     = link[wrot_pkg::TABLE_DEPTH-1];

  always_comb begin
    space     = ~start_block;
    head_next = '0;
    head_next.valid = in_acc;
    head_next.op    = opcode;
    head_next.s     = start_block;
    head_next.n     = block_count;
    // clip the readable length at the top of the address space
    head_next.wl    = (wrot_pkg::ADDR_BITS'(block_count) > space) ?
                      wrot_pkg::LEN_BITS'(space + 1'b1) : block_count;
    head_next.cv    = cursor_valid;
    head_next.cs    = cursor_slot;
    head_next.fill  = fill_level;
  end

  genvar g;
  generate
    for (g = 0; g < wrot_pkg::TABLE_DEPTH; g++) begin : g_cell
      wrot_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_idx (wrot_pkg::SLOT_BITS'(g)),
        .msg_i    ((g == 0) ? head : link[(g == 0) ? 0 : g - 1]),
        .wr0      (wr0),
        .wr1      (wr1),
        .msg_o    (link[g])
      );
    end
  endgenerate

  always_comb begin
    wr0             = '0;
    wr1             = '0;
    fill_level_next = fill_level;
    status_next     = wrot_pkg::ST_NONE;
    slot_next       = '0;
    seg_start_next  = '0;
    seg_count_next  = '0;
    read_start_next = '0;
    read_count_next = '0;
    rejected        = (last.fill == wrot_pkg::FILL_BITS'(wrot_pkg::TABLE_DEPTH)) || last.reject;
    new_idx         = last.fill[wrot_pkg::SLOT_BITS-1:0] +
                      wrot_pkg::SLOT_BITS'(last.split);
    case (last.op)
      wrot_pkg::OP_PUSH: begin
        if (rejected) begin
          status_next = wrot_pkg::ST_FULL;
        end else begin
          wr0.en     = last.valid && last.split;
          wr0.idx    = last.fill[wrot_pkg::SLOT_BITS-1:0];
          wr0.start  = last.sp_start;
          wr0.count  = last.sp_count;
          wr0.rs     = last.s + wrot_pkg::ADDR_BITS'(last.wl);
          wr0.rc     = last.sp_len;
          wr0.copied = last.sp_copied;
          wr1.en     = last.valid;
          wr1.idx    = new_idx;
          wr1.start  = last.s;
          wr1.count  = last.n;
          wr1.rs     = last.s;
          wr1.rc     = last.wl;
          wr1.copied = 1'b0;
          if (last.valid) begin
            fill_level_next = fill_level + 1'b1 + wrot_pkg::FILL_BITS'(last.split);
          end
          status_next     = wrot_pkg::ST_DONE;
          slot_next       = new_idx;
          seg_start_next  = last.s;
          seg_count_next  = last.n;
          read_start_next = last.s;
          read_count_next = last.wl;
        end
      end
      wrot_pkg::OP_GET, wrot_pkg::OP_MARK: begin
        if (last.hit) begin
          status_next     = wrot_pkg::ST_DONE;
          slot_next       = last.r_slot;
          seg_start_next  = last.r_start;
          seg_count_next  = last.r_count;
          read_start_next = last.r_rs;
          read_count_next = last.r_rc;
        end
      end
      default: status_next = wrot_pkg::ST_NONE;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc) state_next = S_RUN;
      S_RUN:   if (last.valid) state_next = S_OUT;
      S_OUT:   if (out_acc) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      state      <= S_IDLE;
      fill_level <= '0;
      out_valid  <= 1'b0;
    end else begin
      head       <= head_next;
      state      <= state_next;
      fill_level <= fill_level_next;
      if (state == S_RUN && last.valid) begin
        out_valid  <= 1'b1;
        status     <= status_next;
        slot       <= slot_next;
        seg_start  <= seg_start_next;
        seg_count  <= seg_count_next;
        read_start <= read_start_next;
        read_count <= read_count_next;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= wrot_pkg::FILL_BITS'(wrot_pkg::TABLE_DEPTH))
    else $error("fill level beyond table depth");

  a_inject: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> head.valid && (state == S_RUN))
    else $error("accepted item not injected into the chain");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && last.valid && last.op == wrot_pkg::OP_PUSH && !rejected)
    |=> fill_level != $past(fill_level))
    else $error("accepted push did not append");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result shown outside output state");

endmodule
